>>> design/rpc_pkg.sv
// Shared types, constants and helpers of the rectangular/polar converter.
// Holds the arctangent table in degrees scaled by 2^24 and the inverse gain.
// Depends on nothing; used by every module of the block.
package rpc_pkg;

  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned ANGLE_BITS = 24;
  // Datapath width for the CORDIC registers (x, y carry 32+8 bits plus growth).
  localparam int unsigned DW = 44;
  // Angle accumulator width: 180 deg << 24 plus margin.
  localparam int unsigned AW = 36;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131495;

  typedef enum logic [1:0] {
    ACT_RECT  = 2'd0,
    ACT_POLAR = 2'd1,
    ACT_BAD2  = 2'd2,
    ACT_BAD3  = 2'd3
  } action_t;

  // Side information carried alongside the CORDIC stages.
  typedef struct packed {
    logic               is_rect;
    logic               is_polar;
    logic               is_zero;
    logic               flip;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } side_t;

  function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    begin
      case (idx)
        5'd0:  v = 36'sd754974720;
        5'd1:  v = 36'sd445687602;
        5'd2:  v = 36'sd235489088;
        5'd3:  v = 36'sd119537938;
        5'd4:  v = 36'sd60000934;
        5'd5:  v = 36'sd30029717;
        5'd6:  v = 36'sd15018523;
        5'd7:  v = 36'sd7509720;
        5'd8:  v = 36'sd3754917;
        5'd9:  v = 36'sd1877466;
        5'd10: v = 36'sd938734;
        5'd11: v = 36'sd469367;
        5'd12: v = 36'sd234684;
        5'd13: v = 36'sd117342;
        5'd14: v = 36'sd58671;
        5'd15: v = 36'sd29335;
        5'd16: v = 36'sd14668;
        5'd17: v = 36'sd7334;
        5'd18: v = 36'sd3667;
        5'd19: v = 36'sd1833;
        5'd20: v = 36'sd917;
        5'd21: v = 36'sd458;
        5'd22: v = 36'sd229;
        5'd23: v = 36'sd115;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
    logic signed [31:0] r;
    begin
      if (v > $signed({{(DW-32){1'b0}}, 32'h7FFFFFFF}))
        r = 32'sh7FFFFFFF;
      else if (v < $signed({{(DW-32){1'b1}}, 32'h80000000}))
        r = 32'sh80000000;
      else
        r = v[31:0];
      return r;
    end
  endfunction

endpackage

>>> design/rect_polar_converter.sv
// Rectangular/polar converter: input prep, CORDIC stage chain, gain removal
// and output register. Depends on rpc_pkg, rpc_stage and rpc_gain.
//
// Usage: words enter on the in_ channel (tdata: action[1:0],
// first_value[33:2], second_value[65:34]) and leave on the out_ channel
// (tdata: x_coord, y_coord, magnitude(33), angle_degrees, bad_mode).
// Action 0 converts x,y to magnitude and angle in degrees; action 1 turns
// a magnitude and angle into x,y; other actions return zeros with bad_mode.
// Throughput: one word per cycle unless out_tready stalls the pipeline.
// Pipeline: two prep stages, one stage per CORDIC rotation, two for the
// gain multiply and one output stage.
// The whole pipeline advances together; when the receiver holds
// out_tready low while the output register is full, every stage holds and
// in_tready falls, so nothing is lost or repeated. Reset clears all valid
// bits; data registers are not reset.
module rect_polar_converter #(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,  // action[1:0], first_value[33:2], second_value[65:34]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata  // x[31:0], y[63:32], mag[96:64], angle[128:97], bad[129]
);

  localparam int unsigned N      = (CORDIC_STEPS < rpc_pkg::TABLE_LEN) ?
                                   CORDIC_STEPS : rpc_pkg::TABLE_LEN;
  localparam int unsigned ASHIFT = rpc_pkg::ANGLE_BITS - FRACTION_BITS;
  localparam int unsigned DW     = rpc_pkg::DW;
  localparam int unsigned AW     = rpc_pkg::AW;
  localparam logic signed [AW-1:0] DEG90  = AW'(64'sd90 <<< rpc_pkg::ANGLE_BITS);
  localparam logic signed [AW-1:0] DEG180 = AW'(64'sd180 <<< rpc_pkg::ANGLE_BITS);
  // 360 = 45 * 8: the low FRACTION_BITS + 3 bits pass through untouched
  localparam int unsigned          RSH      = FRACTION_BITS + 3;
  localparam logic [39:0]          LOW_MASK = (40'd1 << RSH) - 40'd1;
  // 45 * 2^15 keeps the shifted angle positive without changing its residue
  localparam logic signed [31:0]   RES_BIAS = 32'sd1474560;
  localparam logic [22:0]          RECIP45  = 23'd5965233;  // ceil(2^28 / 45)

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic [1:0]         act;
  logic signed [31:0] fv, sv;
  assign act = in_tdata[1:0];
  assign fv  = in_tdata[33:2];
  assign sv  = in_tdata[65:34];

  // Stage A: angle reduction (remainder register stage before quadrant prep)
  logic               a_valid_r;
  logic [1:0]         a_act_r;
  logic signed [31:0] a_fv_r, a_sv_r;
  logic signed [39:0] a_rem_r;
  logic signed [39:0] rem_nxt;
  logic               in_acc;
  logic signed [31:0] turn_s;
  logic [21:0]        turn_u;
  logic [44:0]        quot_prod;
  logic [21:0]        quot;
  logic [21:0]        res45;
  assign in_acc = in_tvalid && in_tready;

  // Angle modulo 360 degrees, always non-negative: reduce the part above the
  // low bits modulo 45 by reciprocal multiplication, then reattach them.
  always_comb begin
    turn_s    = (sv >>> RSH) + RES_BIAS;
    turn_u    = turn_s[21:0];
    quot_prod = 45'(turn_u) * 45'(RECIP45);
    quot      = 22'(quot_prod >> 28);
    res45     = turn_u - 22'(quot * 22'd45);
    rem_nxt   = $signed((40'(res45[5:0]) << RSH) | (40'(sv) & LOW_MASK));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else if (en) a_valid_r <= in_acc;
    if (en) begin
      a_act_r <= act;
      a_fv_r  <= fv;
      a_sv_r  <= sv;
      a_rem_r <= rem_nxt;
    end
  end

  // Stage B: quadrant preparation
  logic                   p_valid_r;
  logic signed [DW-1:0]   p_x_r, p_y_r, px, py;
  logic signed [AW-1:0]   p_z_r, pz;
  rpc_pkg::side_t         p_side_r, ps;

  always_comb begin
    logic signed [AW-1:0] zr;
    ps.is_rect      = (a_act_r == rpc_pkg::ACT_RECT);
    ps.is_polar     = (a_act_r == rpc_pkg::ACT_POLAR);
    ps.is_zero      = (a_fv_r == 0) && (a_sv_r == 0);
    ps.flip         = 1'b0;
    ps.first_value  = a_fv_r;
    ps.second_value = a_sv_r;
    px = DW'(a_fv_r) <<< rpc_pkg::GUARD_BITS;
    py = DW'(a_sv_r) <<< rpc_pkg::GUARD_BITS;
    pz = '0;
    zr = AW'(a_rem_r) <<< ASHIFT;
    if (ps.is_rect) begin
      if (a_fv_r < 0) begin
        pz = (a_sv_r >= 0) ? DEG180 : -DEG180;
        px = -px;
        py = -py;
      end
    end else begin
      py = '0;
      if (zr > DEG180) zr = zr - (DEG180 <<< 1);
      if (zr > DEG90) begin
        zr = zr - DEG180;
        ps.flip = 1'b1;
      end else if (zr < -DEG90) begin
        zr = zr + DEG180;
        ps.flip = 1'b1;
      end
      pz = zr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_valid_r <= 1'b0;
    else if (en) p_valid_r <= a_valid_r;
    if (en) begin
      p_x_r    <= px;
      p_y_r    <= py;
      p_z_r    <= pz;
      p_side_r <= ps;
    end
  end

  // CORDIC chain
  logic                 c_valid [N+1];
  logic signed [DW-1:0] c_x [N+1];
  logic signed [DW-1:0] c_y [N+1];
  logic signed [AW-1:0] c_z [N+1];
  rpc_pkg::side_t       c_side [N+1];

  assign c_valid[0] = p_valid_r;
  assign c_x[0]     = p_x_r;
  assign c_y[0]     = p_y_r;
  assign c_z[0]     = p_z_r;
  assign c_side[0]  = p_side_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    rpc_stage #(.STEP(i)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(c_valid[i]), .in_x(c_x[i]), .in_y(c_y[i]), .in_z(c_z[i]),
      .in_side(c_side[i]),
      .out_valid(c_valid[i+1]), .out_x(c_x[i+1]), .out_y(c_y[i+1]),
      .out_z(c_z[i+1]), .out_side(c_side[i+1])
    );
  end

  // Gain removal (two stages) with side data delayed alongside
  logic signed [DW-1:0] gx, gy;
  rpc_gain u_gain_x (.clk(clk), .en(en), .in_v(c_x[N]), .out_v(gx));
  rpc_gain u_gain_y (.clk(clk), .en(en), .in_v(c_y[N]), .out_v(gy));

  logic                 g_valid_r [2];
  logic signed [AW-1:0] g_z_r [2];
  rpc_pkg::side_t       g_side_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r[0] <= 1'b0;
      g_valid_r[1] <= 1'b0;
    end else if (en) begin
      g_valid_r[0] <= c_valid[N];
      g_valid_r[1] <= g_valid_r[0];
    end
    if (en) begin
      g_z_r[0]    <= c_z[N];
      g_z_r[1]    <= g_z_r[0];
      g_side_r[0] <= c_side[N];
      g_side_r[1] <= g_side_r[0];
    end
  end

  // Output stage
  logic signed [31:0] x_nxt, y_nxt, a_nxt;
  logic signed [32:0] m_nxt;
  logic               bad_nxt;
  logic [135:0]       out_data_r;

  always_comb begin
    logic signed [AW-1:0] zz;
    rpc_pkg::side_t s;
    s = g_side_r[1];
    x_nxt = '0; y_nxt = '0; m_nxt = '0; a_nxt = '0; bad_nxt = 1'b0;
    zz = g_z_r[1];
    if (ASHIFT > 0) zz = (zz + AW'(64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT;
    if (s.is_rect) begin
      x_nxt = s.first_value;
      y_nxt = s.second_value;
      if (!s.is_zero) begin
        m_nxt = gx[32:0];
        a_nxt = rpc_pkg::sat32(DW'(zz));
      end
    end else if (s.is_polar) begin
      x_nxt = rpc_pkg::sat32(s.flip ? -gx : gx);
      y_nxt = rpc_pkg::sat32(s.flip ? -gy : gy);
      m_nxt = 33'(s.first_value);
      a_nxt = s.second_value;
    end else begin
      bad_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= g_valid_r[1];
    if (en) out_data_r <= {6'd0, bad_nxt, a_nxt, m_nxt, y_nxt, x_nxt};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output word changed while stalled");
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[129] |-> out_tdata[128:0] == '0)
    else $error("bad mode word not zero");

endmodule

>>> design/rpc_stage.sv
// One CORDIC micro-rotation stage with its pipeline register.
// Works in vectoring (rectangular) or rotation (polar) mode per word.
// Depends on rpc_pkg.
module rpc_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [rpc_pkg::DW-1:0] in_x,
  input  logic signed [rpc_pkg::DW-1:0] in_y,
  input  logic signed [rpc_pkg::AW-1:0] in_z,
  input  rpc_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic signed [rpc_pkg::DW-1:0] out_x,
  output logic signed [rpc_pkg::DW-1:0] out_y,
  output logic signed [rpc_pkg::AW-1:0] out_z,
  output rpc_pkg::side_t                out_side
);

  logic signed [rpc_pkg::DW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [rpc_pkg::AW-1:0] z_nxt, at;
  logic                          up;
  logic                          valid_r;
  logic signed [rpc_pkg::DW-1:0] x_r, y_r;
  logic signed [rpc_pkg::AW-1:0] z_r;
  rpc_pkg::side_t                side_r;

  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
    at = rpc_pkg::atan_entry(5'(STEP));
    // Vectoring drives y to zero; rotation drives z to zero.
    up = in_side.is_rect ? (in_y >= 0) : (in_z < 0);
    if (up) begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + at;
    end else begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_side  = side_r;

endmodule

>>> design/rpc_gain.sv
// Gain removal: round(|v| * INV_GAIN / 2^40) half away from zero.
// Two register stages so the multiply has a register after it.
// Depends on rpc_pkg.
module rpc_gain (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rpc_pkg::DW-1:0] in_v,
  output logic signed [rpc_pkg::DW-1:0] out_v
);

  logic                    neg_r, neg2_r;
  logic [rpc_pkg::DW-1:0]  a_nxt;
  logic [63:0]             hi_r, lo_r;
  logic [63:0]             p;
  logic [63:0]             q;
  logic [rpc_pkg::DW-1:0]  mag_r;

  always_comb begin
    a_nxt = in_v[rpc_pkg::DW-1] ? rpc_pkg::DW'(-in_v) : rpc_pkg::DW'(in_v);
    p = hi_r + (lo_r >> 16);
    q = (p + (64'd1 << 23)) >> 24;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= in_v[rpc_pkg::DW-1];
      hi_r   <= 64'(a_nxt[rpc_pkg::DW-1:16]) * 64'(rpc_pkg::INV_GAIN_Q32);
      lo_r   <= 64'(a_nxt[15:0]) * 64'(rpc_pkg::INV_GAIN_Q32);
      neg2_r <= neg_r;
      mag_r  <= q[rpc_pkg::DW-1:0];
    end
  end

  assign out_v = neg2_r ? -$signed(mag_r) : $signed(mag_r);

endmodule
